// ----- rtl/md5_pkg.sv -----
// Shared types, constants and round tables for the MD5 hash engine.
package md5_pkg;

    localparam int S_DATA_W    = 40;
    localparam int M_DATA_W    = 128;
    localparam int WORD_W      = 32;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef logic [3:0][WORD_W-1:0] chain_t;

    localparam chain_t CHAIN_INIT = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

    typedef enum logic [1:0] {
        ITEM_DATA,
        ITEM_LAST_FULL,
        ITEM_LAST_PART
    } item_kind_t;

    typedef struct packed {
        item_kind_t        kind;
        logic [WORD_W-1:0] word;
        logic [5:0]        add_bits;
    } item_t;

    typedef struct packed {
        logic              buf_we;
        logic [3:0]        buf_addr;
        logic [WORD_W-1:0] buf_data;
        logic              start;
        logic              restart;
    } cmp_ctrl_t;

    typedef enum logic [2:0] {
        BK_FETCH,
        BK_EXTRA,
        BK_ZERO,
        BK_LEN_LO,
        BK_LEN_HI,
        BK_COMP,
        BK_DONE
    } back_state_t;

    function automatic logic [WORD_W-1:0] round_const(input logic [5:0] r);
        logic [WORD_W-1:0] k;
        unique case (r)
            6'd0:  k = 32'hd76aa478;
            6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;
            6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;
            6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;
            6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;
            6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;
            6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;
            6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;
            6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;
            6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;
            6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;
            6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;
            6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;
            6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;
            6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;
            6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;
            6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;
            6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;
            6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;
            6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;
            6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;
            6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;
            6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;
            6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;
            default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [3:0] idx);
        logic [4:0] s;
        unique case (idx)
            4'd0:  s = 5'd7;
            4'd1:  s = 5'd12;
            4'd2:  s = 5'd17;
            4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;
            4'd5:  s = 5'd9;
            4'd6:  s = 5'd14;
            4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;
            4'd9:  s = 5'd11;
            4'd10: s = 5'd16;
            4'd11: s = 5'd23;
            4'd12: s = 5'd6;
            4'd13: s = 5'd10;
            4'd14: s = 5'd15;
            default: s = 5'd21;
        endcase
        return s;
    endfunction

    function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
                                                 input logic [4:0] s);
        logic [2*WORD_W-1:0] tmp;
        tmp = {x, x} << s;
        return tmp[2*WORD_W-1:WORD_W];
    endfunction

endpackage

// ----- rtl/md5_front.sv -----
// Input stage: accepts beats, classifies them and queues them for the back end.
module md5_front #(
    parameter int QUEUE_DEPTH = md5_pkg::QUEUE_DEPTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // s_tdata: message_word [31:0], byte_count [34:32], zero fill [39:35]
    input  logic [md5_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                         s_tlast,
    output md5_pkg::item_t               q_item,
    output logic                         q_valid,
    input  logic                         q_pop
);
    import md5_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    item_t             in_item;
    logic [2:0]        sat_count;
    logic [WORD_W-1:0] in_word;
    logic              do_push;
    logic              do_pop;

    assign in_word = s_tdata[WORD_W-1:0];
    assign sat_count = (s_tdata[34:32] > 3'd4) ? 3'd4 : s_tdata[34:32];

    always_comb begin
        in_item.kind     = ITEM_DATA;
        in_item.word     = in_word;
        in_item.add_bits = 6'd32;
        if (s_tlast) begin
            if (sat_count == 3'd4) begin
                in_item.kind = ITEM_LAST_FULL;
            end else begin
                in_item.kind     = ITEM_LAST_PART;
                in_item.add_bits = {1'b0, sat_count[1:0], 3'b000};
                unique case (sat_count[1:0])
                    2'd0:    in_item.word = {24'h000000, PAD_BYTE};
                    2'd1:    in_item.word = {16'h0000, PAD_BYTE, in_word[7:0]};
                    2'd2:    in_item.word = {8'h00, PAD_BYTE, in_word[15:0]};
                    default: in_item.word = {PAD_BYTE, in_word[23:0]};
                endcase
            end
        end
    end

    assign s_tready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = queue_reg[rd_ptr_reg];
    assign do_push  = s_tvalid && s_tready;
    assign do_pop   = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            queue_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ----- rtl/md5_compress.sv -----
// Block buffer, chaining words and the single-round MD5 compression unit.
module md5_compress (
    input  logic                aclk,
    input  logic                aresetn,
    input  md5_pkg::cmp_ctrl_t  ctrl,
    output logic                done,
    output md5_pkg::chain_t     chain
);
    import md5_pkg::*;

    logic [WORD_W-1:0] buffer_reg [16];
    chain_t            chain_reg, chain_next;
    chain_t            round_reg, round_next;
    logic [5:0]        rnd_reg, rnd_next;
    logic              run_reg, run_next;

    logic [WORD_W-1:0] a, b, c, d;
    logic [WORD_W-1:0] f;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] b_new;
    logic [3:0]        g;
    logic [1:0]        phase;

    assign a     = round_reg[0];
    assign b     = round_reg[1];
    assign c     = round_reg[2];
    assign d     = round_reg[3];
    assign phase = rnd_reg[5:4];

    always_comb begin
        unique case (phase)
            2'd0: begin
                f = (b & c) | (~b & d);
                g = rnd_reg[3:0];
            end
            2'd1: begin
                f = (b & d) | (c & ~d);
                g = 4'(rnd_reg[3:0] * 4'd5 + 4'd1);
            end
            2'd2: begin
                f = b ^ c ^ d;
                g = 4'(rnd_reg[3:0] * 4'd3 + 4'd5);
            end
            default: begin
                f = c ^ (b | ~d);
                g = 4'(rnd_reg[3:0] * 4'd7);
            end
        endcase
        sum   = a + f + round_const(rnd_reg) + buffer_reg[g];
        b_new = b + rotl32(sum, rot_amount({phase, rnd_reg[1:0]}));
    end

    always_comb begin
        round_next = round_reg;
        chain_next = chain_reg;
        rnd_next   = rnd_reg;
        run_next   = run_reg;
        done       = 1'b0;
        if (ctrl.restart) begin
            chain_next = CHAIN_INIT;
        end
        if (run_reg) begin
            round_next = {c, b, b_new, d};
            rnd_next   = rnd_reg + 1'b1;
            if (rnd_reg == 6'd63) begin
                run_next      = 1'b0;
                done          = 1'b1;
                chain_next[0] = chain_reg[0] + d;
                chain_next[1] = chain_reg[1] + b_new;
                chain_next[2] = chain_reg[2] + b;
                chain_next[3] = chain_reg[3] + c;
            end
        end else if (ctrl.start) begin
            round_next = chain_reg;
            rnd_next   = '0;
            run_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg <= CHAIN_INIT;
            rnd_reg   <= '0;
            run_reg   <= 1'b0;
        end else begin
            chain_reg <= chain_next;
            rnd_reg   <= rnd_next;
            run_reg   <= run_next;
        end
    end

    always_ff @(posedge aclk) begin
        round_reg <= round_next;
        if (ctrl.buf_we) begin
            buffer_reg[ctrl.buf_addr] <= ctrl.buf_data;
        end
    end

    assign chain = chain_reg;

endmodule

// ----- rtl/md5_back.sv -----
// Back end sequencer: fills the block buffer, adds padding and length, drives the digest.
module md5_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  md5_pkg::item_t               q_item,
    input  logic                         q_valid,
    output logic                         q_pop,
    output md5_pkg::cmp_ctrl_t           ctrl,
    input  logic                         cmp_done,
    input  md5_pkg::chain_t              chain,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // m_tdata: digest_low [63:0], digest_high [127:64]
    output logic [md5_pkg::M_DATA_W-1:0] m_tdata
);
    import md5_pkg::*;

    back_state_t         state_reg, state_next;
    back_state_t         resume_reg, resume_next;
    back_state_t         after_push;
    logic [3:0]          idx_reg, idx_next;
    logic [63:0]         len_reg, len_next;
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic                push;
    logic [WORD_W-1:0]   push_word;
    logic                out_load;

    always_comb begin
        state_next  = state_reg;
        resume_next = resume_reg;
        idx_next    = idx_reg;
        len_next    = len_reg;
        after_push  = BK_FETCH;
        push        = 1'b0;
        push_word   = '0;
        q_pop       = 1'b0;
        out_load    = 1'b0;
        ctrl        = '0;

        unique case (state_reg)
            BK_FETCH: begin
                if (q_valid) begin
                    q_pop     = 1'b1;
                    push      = 1'b1;
                    push_word = q_item.word;
                    len_next  = len_reg + 64'(q_item.add_bits);
                    unique case (q_item.kind)
                        ITEM_LAST_FULL: after_push = BK_EXTRA;
                        ITEM_LAST_PART: after_push = BK_ZERO;
                        default:        after_push = BK_FETCH;
                    endcase
                end
            end
            BK_EXTRA: begin
                push       = 1'b1;
                push_word  = {24'h000000, PAD_BYTE};
                after_push = BK_ZERO;
            end
            BK_ZERO: begin
                if (idx_reg == 4'd14) begin
                    state_next = BK_LEN_LO;
                end else begin
                    push       = 1'b1;
                    after_push = BK_ZERO;
                end
            end
            BK_LEN_LO: begin
                push       = 1'b1;
                push_word  = len_reg[31:0];
                after_push = BK_LEN_HI;
            end
            BK_LEN_HI: begin
                push       = 1'b1;
                push_word  = len_reg[63:32];
                after_push = BK_DONE;
            end
            BK_COMP: begin
                if (cmp_done) begin
                    state_next = resume_reg;
                end
            end
            BK_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    out_load     = 1'b1;
                    ctrl.restart = 1'b1;
                    len_next     = '0;
                    state_next   = BK_FETCH;
                end
            end
            default: state_next = BK_FETCH;
        endcase

        if (push) begin
            ctrl.buf_we   = 1'b1;
            ctrl.buf_addr = idx_reg;
            ctrl.buf_data = push_word;
            idx_next      = idx_reg + 1'b1;
            if (idx_reg == 4'd15) begin
                ctrl.start  = 1'b1;
                state_next  = BK_COMP;
                resume_next = after_push;
            end else begin
                state_next = after_push;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_FETCH;
            resume_reg  <= BK_FETCH;
            idx_reg     <= '0;
            len_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            resume_reg <= resume_next;
            idx_reg    <= idx_next;
            len_reg    <= len_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= chain;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ----- rtl/md5_hash_engine_top.sv -----
// Top level of the streaming MD5 hash engine.
// The compression unit computes one round per cycle; while a block is being compressed
// the back end takes no new message words from the queue.
// After the last beat, with the back end idle, the back end writes the padding and length words
// and runs one or two further block compressions before the digest beat is loaded.
// Reset: queue empty, chaining words at the MD5 initial values; the buffer is not cleared.
module md5_hash_engine_top #(
    parameter int QUEUE_DEPTH = md5_pkg::QUEUE_DEPTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // s_tdata: message_word [31:0], byte_count [34:32], zero fill [39:35]
    input  logic [md5_pkg::S_DATA_W-1:0] s_tdata,
    // s_tlast: last
    input  logic                         s_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // m_tdata: digest_low [63:0], digest_high [127:64]
    output logic [md5_pkg::M_DATA_W-1:0] m_tdata
);
    import md5_pkg::*;

    item_t     q_item;
    logic      q_valid;
    logic      q_pop;
    cmp_ctrl_t ctrl;
    logic      cmp_done;
    chain_t    chain;

    md5_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .q_item  (q_item),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    md5_compress u_compress (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctrl   (ctrl),
        .done   (cmp_done),
        .chain  (chain)
    );

    md5_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_item  (q_item),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .ctrl    (ctrl),
        .cmp_done(cmp_done),
        .chain   (chain),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

endmodule
